/* src/wpmc_pkg.sv */
package wpmc_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int BYTE_W          = 8;
	localparam int LEN_REG_W       = 5;
	localparam int CHARS_W         = 64;
	localparam int NUM_CHARS       = 16;
	localparam int CHAR_IDX_W      = 4;
	localparam int COUNT_W         = 16;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 64;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LENGTH     = 2'd0,
		CFG_CHARS_LOW  = 2'd1,
		CFG_CHARS_HIGH = 2'd2
	} cfg_idx_t;

	localparam logic [BYTE_W-1:0] CH_STAR    = 8'h2A;
	localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
	localparam logic [BYTE_W-1:0] CH_AT      = 8'h40;
	localparam logic [BYTE_W-1:0] CH_LO_A    = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LO_Z    = 8'h7A;
	localparam logic [BYTE_W-1:0] CH_UP_A    = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UP_Z    = 8'h5A;
	localparam logic [BYTE_W-1:0] CH_0       = 8'h30;
	localparam logic [BYTE_W-1:0] CH_9       = 8'h39;

	function automatic logic is_letter(input logic [BYTE_W-1:0] c);
		return ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
	endfunction

	function automatic logic char_match(input logic [BYTE_W-1:0] p,
		input logic [BYTE_W-1:0] t);
		logic r;
		r = 1'b0;
		if (p == CH_STAR) begin
			r = 1'b1;
		end else if (p == CH_PERCENT) begin
			r = (t >= CH_0) && (t <= CH_9);
		end else if (p == CH_AT) begin
			r = is_letter(t);
		end else if (is_letter(p)) begin
			r = (p == t);
		end
		return r;
	endfunction

endpackage

/* src/wpmc_cfg.sv */
module wpmc_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [wpmc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wpmc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic [wpmc_pkg::LEN_REG_W-1:0]     pattern_length,
	output logic [2*wpmc_pkg::CHARS_W-1:0]     pattern_chars
);
	import wpmc_pkg::*;

	logic [LEN_REG_W-1:0] length_q;
	logic [CHARS_W-1:0]   low_q;
	logic [CHARS_W-1:0]   high_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= LEN_REG_W'(1);
			low_q    <= '0;
			high_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_LENGTH:     length_q <= cfg_data[LEN_REG_W-1:0];
				CFG_CHARS_LOW:  low_q    <= cfg_data[CHARS_W-1:0];
				CFG_CHARS_HIGH: high_q   <= cfg_data[CHARS_W-1:0];
				default: ;
			endcase
		end
	end

	assign pattern_length = length_q;
	assign pattern_chars  = {high_q, low_q};

endmodule

/* src/wpmc_matcher.sv */
module wpmc_matcher #(
	parameter int MaxPattern = wpmc_pkg::MAX_PATTERN_DEF,
	localparam int LW = $clog2(MaxPattern + 1)
) (
	input  logic [wpmc_pkg::LEN_REG_W-1:0]          pattern_length,
	input  logic [2*wpmc_pkg::CHARS_W-1:0]          pattern_chars,
	input  logic [LW-1:0]                           bytes_seen,
	input  logic [MaxPattern-1:0][wpmc_pkg::BYTE_W-1:0] window,
	output logic                                    hit
);
	import wpmc_pkg::*;

	logic [NUM_CHARS-1:0][BYTE_W-1:0] pchar;
	logic [LW-1:0]                    len_eff;
	logic [MaxPattern-1:0]            pos_ok;
	logic                             full;

	assign pchar = pattern_chars;

	always_comb begin
		if (pattern_length == '0) begin
			len_eff = LW'(1);
		end else if (pattern_length > LEN_REG_W'(MaxPattern)) begin
			len_eff = LW'(MaxPattern);
		end else begin
			len_eff = LW'(pattern_length);
		end
	end

	// window[0] is the newest byte; it faces the last pattern character in use
	always_comb begin
		logic [LW-1:0] k;
		for (int j = 0; j < MaxPattern; j++) begin
			k = len_eff - LW'(1) - LW'(j);
			if (LW'(j) >= len_eff) begin
				pos_ok[j] = 1'b1;
			end else begin
				pos_ok[j] = char_match(pchar[CHAR_IDX_W'(k)], window[j]);
			end
		end
	end

	assign full = ({1'b0, bytes_seen} + (LW+1)'(1)) >= {1'b0, len_eff};
	assign hit  = full && (&pos_ok);

endmodule

/* src/wildcard_pattern_match_counter.sv */
// The input register captures each input transaction, one matcher pass follows, and the
// result register holds the outcome until it is taken.
// Throughput: one byte per cycle unless m_axis_tready stalls the output; the
// MaxPattern-position (default 16) history compare is combinational between the two registers.
// Reset (arst_n low): config returns to length 1 and zero characters; history,
// byte count, match count and the valid flags of both pipeline stages are cleared.
module wildcard_pattern_match_counter #(
	parameter int MaxPattern = wpmc_pkg::MAX_PATTERN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [7:0]                      s_axis_tdata,  // text_byte
	input  logic                            s_axis_tlast,  // end_of_text
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [15:0]                     m_axis_tdata,  // match_count
	output logic                            m_axis_tuser,  // match_here
	output logic                            m_axis_tlast,  // text_done
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wpmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wpmc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import wpmc_pkg::*;

	localparam int LW        = $clog2(MaxPattern + 1);
	localparam int HistDepth = (MaxPattern > 1) ? MaxPattern - 1 : 1;

	logic [LEN_REG_W-1:0]              pattern_length;
	logic [2*CHARS_W-1:0]              pattern_chars;

	logic                              valid_s1;
	logic [BYTE_W-1:0]                 byte_s1;
	logic                              last_s1;

	logic                              valid_s2;
	logic [COUNT_W-1:0]                count_s2;
	logic                              hit_s2;
	logic                              last_s2;

	logic [HistDepth-1:0][BYTE_W-1:0]  hist_q;
	logic [LW-1:0]                     seen_q;
	logic [COUNT_W-1:0]                count_q;

	logic [MaxPattern-1:0][BYTE_W-1:0] window;
	logic                              hit;
	logic                              adv;
	logic [COUNT_W-1:0]                count_next;

	wpmc_cfg u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pattern_length (pattern_length),
		.pattern_chars  (pattern_chars)
	);

	always_comb begin
		window[0] = byte_s1;
		for (int j = 1; j < MaxPattern; j++) begin
			window[j] = hist_q[j-1];
		end
	end

	wpmc_matcher #(
		.MaxPattern (MaxPattern)
	) u_matcher (
		.pattern_length (pattern_length),
		.pattern_chars  (pattern_chars),
		.bytes_seen     (seen_q),
		.window         (window),
		.hit            (hit)
	);

	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign count_next    = (hit && (count_q != COUNT_MAX)) ? count_q + COUNT_W'(1) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			count_s2 <= count_next;
			hit_s2   <= hit;
			last_s2  <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			seen_q  <= '0;
			count_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				hist_q  <= '0;
				seen_q  <= '0;
				count_q <= '0;
			end else begin
				hist_q[0] <= byte_s1;
				for (int i = 1; i < HistDepth; i++) begin
					hist_q[i] <= hist_q[i-1];
				end
				if (seen_q != LW'(MaxPattern)) begin
					seen_q <= seen_q + LW'(1);
				end
				count_q <= count_next;
			end
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = count_s2;
	assign m_axis_tuser  = hit_s2;
	assign m_axis_tlast  = last_s2;

endmodule

/* src/wpmc_checker.sv */
module wpmc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast
);
	import wpmc_pkg::*;

	logic               fresh_q;
	logic [COUNT_W-1:0] prev_count_q;
	logic [COUNT_W-1:0] base;
	logic [COUNT_W-1:0] expected;
	logic               out_xfer;

	assign out_xfer = m_axis_tvalid && m_axis_tready;
	assign base     = fresh_q ? '0 : prev_count_q;
	assign expected = (m_axis_tuser && (base != COUNT_MAX)) ? base + COUNT_W'(1) : base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q      <= 1'b1;
			prev_count_q <= '0;
		end else if (out_xfer) begin
			fresh_q      <= m_axis_tlast;
			prev_count_q <= m_axis_tdata;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> m_axis_tdata == expected)
		else $error("match count does not follow match flags");

	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && m_axis_tuser |-> m_axis_tdata != '0)
		else $error("match reported with zero count");

endmodule

bind wildcard_pattern_match_counter wpmc_checker u_wpmc_checker (.*);

/* verif/tb_wildcard_pattern_match_counter.sv */
`timescale 1ns / 100ps

module tb_wildcard_pattern_match_counter;
	import wpmc_pkg::*;

	localparam int                 CYCLE_LIMIT  = 400000;
	localparam int                 HOLD_CYCLES  = 200;
	localparam int                 PHASE_ITEMS  = 70;
	localparam int                 TAIL_LEN     = 40;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct {
		logic        hit;
		logic [15:0] count;
		logic        done;
	} match_result_t;

	class match_scoreboard;
		bit [4:0]      len_reg;
		bit [63:0]     chars_lo;
		bit [63:0]     chars_hi;
		bit [7:0]      history [MAX_PATTERN_DEF-1];
		int            bytes_seen;
		bit [15:0]     running_count;
		match_result_t pending_q [$];
		int            errors;
		int            results_seen;
		int            texts_done;

		function new();
			len_reg = 5'd1;
			chars_lo = '0;
			chars_hi = '0;
			foreach (history[i]) history[i] = '0;
			bytes_seen = 0;
			running_count = '0;
			errors = 0;
			results_seen = 0;
			texts_done = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_LENGTH:     len_reg = data[4:0];
				CFG_CHARS_LOW:  chars_lo = data;
				CFG_CHARS_HIGH: chars_hi = data;
				default: ;
			endcase
		endfunction

		function bit [7:0] pat_char(int k);
			if (k < 8) return chars_lo[8*k +: 8];
			return chars_hi[8*(k-8) +: 8];
		endfunction

		function bit class_hit(bit [7:0] p, bit [7:0] t);
			bit p_letter;
			bit t_letter;
			bit t_digit;
			p_letter = (p >= CH_LO_A && p <= CH_LO_Z) || (p >= CH_UP_A && p <= CH_UP_Z);
			t_letter = (t >= CH_LO_A && t <= CH_LO_Z) || (t >= CH_UP_A && t <= CH_UP_Z);
			t_digit = (t >= CH_0 && t <= CH_9);
			if (p == CH_STAR) return 1'b1;
			if (p == CH_PERCENT) return t_digit;
			if (p == CH_AT) return t_letter;
			return p_letter && (p == t);
		endfunction

		function void note_text_byte(bit [7:0] t, bit eot);
			int            n;
			int            back;
			bit            hit;
			bit [7:0]      b;
			match_result_t r;
			n = (len_reg == 0) ? 1 : ((len_reg > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : len_reg);
			hit = (bytes_seen + 1 >= n);
			if (hit) begin
				for (int k = 0; k < n; k++) begin
					back = n - 1 - k;
					b = (back == 0) ? t : history[back-1];
					if (!class_hit(pat_char(k), b)) hit = 1'b0;
				end
			end
			if (hit && running_count != COUNT_MAX) running_count++;
			r.hit = hit;
			r.count = running_count;
			r.done = eot;
			pending_q.push_back(r);
			if (eot) begin
				foreach (history[i]) history[i] = '0;
				bytes_seen = 0;
				running_count = '0;
				texts_done++;
			end else begin
				for (int k = MAX_PATTERN_DEF - 2; k > 0; k--) history[k] = history[k-1];
				history[0] = t;
				if (bytes_seen < MAX_PATTERN_DEF) bytes_seen++;
			end
		endfunction

		task report(string msg);
			if (errors < 100) $display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic hit, logic [15:0] count, logic done);
			match_result_t want;
			results_seen++;
			if (pending_q.size() == 0) begin
				report($sformatf("unexpected result match_here=%b count=%0d", hit, count));
				return;
			end
			want = pending_q.pop_front();
			if (hit !== want.hit)
				report($sformatf("result %0d match_here %b, want %b",
					results_seen, hit, want.hit));
			if (count !== want.count)
				report($sformatf("result %0d match_count %0d, want %0d",
					results_seen, count, want.count));
			if (done !== want.done)
				report($sformatf("result %0d text_done %b, want %b",
					results_seen, done, want.done));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata;
	logic                  s_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [15:0]           m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	match_scoreboard sb = new();

	bit       src_idle;
	bit       sink_idle;
	bit       long_hold;
	int       cycle_count;
	int       bytes_sent;
	int       settings_done;
	bit [7:0] pat [MAX_PATTERN_DEF];
	int       gen_len;

	wildcard_pattern_match_counter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_text_byte(s_axis_tdata, s_axis_tlast);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
	end

	// result sink: random stall bursts plus one long hold to back up the pipe
	initial begin
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		m_axis_tready <= 1'b1;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				long_hold = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else if (sink_idle && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end
		end
	end

	task send_byte(logic [7:0] b, logic last);
		if (src_idle && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		bytes_sent++;
	endtask

	task send_str(string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
	endtask

	// stop the byte stream and let the pipe drain before touching registers
	task settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		sb.write_reg(idx, data);
	endtask

	task program_pattern(logic [4:0] len, logic [63:0] lo, logic [63:0] hi);
		write_cfg(CFG_LENGTH, {59'd0, len});
		write_cfg(CFG_CHARS_LOW, lo);
		write_cfg(CFG_CHARS_HIGH, hi);
		cfg_valid <= 1'b0;
		settings_done++;
	endtask

	function automatic logic [63:0] pack_chars(string s);
		logic [63:0] v;
		v = '0;
		for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
		return v;
	endfunction

	function automatic logic [7:0] rand_letter();
		int v;
		v = $urandom_range(0, 51);
		return (v < 26) ? 8'(CH_LO_A + v) : 8'(CH_UP_A + (v - 26));
	endfunction

	function automatic logic [7:0] rand_text_byte();
		case ($urandom_range(0, 4))
			0, 1: return rand_letter();
			2: return 8'(CH_0 + $urandom_range(0, 9));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] rand_pattern_char();
		case ($urandom_range(0, 9))
			0, 1, 2: return CH_STAR;
			3, 4: return CH_PERCENT;
			5, 6: return CH_AT;
			7, 8: return rand_letter();
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// a byte that satisfies pattern char p (chars that are neither a class nor a letter can never be satisfied)
	function automatic logic [7:0] fit_byte(logic [7:0] p);
		if (p == CH_STAR) return 8'($urandom_range(0, 255));
		if (p == CH_PERCENT) return 8'(CH_0 + $urandom_range(0, 9));
		if (p == CH_AT) return rand_letter();
		return p;
	endfunction

	task set_random_pattern(logic [4:0] len);
		logic [63:0] lo;
		logic [63:0] hi;
		foreach (pat[k]) pat[k] = rand_pattern_char();
		// mostly clean patterns so hits are frequent
		if ($urandom_range(0, 3) != 0)
			foreach (pat[k]) if (pat[k] > CH_LO_Z) pat[k] = CH_STAR;
		for (int k = 0; k < 8; k++) begin
			lo[8*k +: 8] = pat[k];
			hi[8*k +: 8] = pat[k+8];
		end
		gen_len = (len == 0) ? 1 : ((len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : len);
		program_pattern(len, lo, hi);
	endtask

	task send_random_text();
		logic [7:0] txt [$];
		int         tlen;
		int         cut;
		tlen = $urandom_range(1, gen_len + 24);
		while (txt.size() < tlen) begin
			case ($urandom_range(0, 7))
				0, 1, 2: for (int k = 0; k < gen_len; k++) txt.push_back(fit_byte(pat[k]));
				3: begin
					cut = $urandom_range(0, gen_len - 1);
					for (int k = 0; k < cut; k++) txt.push_back(fit_byte(pat[k]));
					txt.push_back(rand_text_byte());
				end
				default: txt.push_back(rand_text_byte());
			endcase
		end
		foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
	endtask

	initial begin
		int lens [10];
		int phase_start;
		lens = '{1, 16, 0, 31, 2, 3, 17, 5, 8, 0};
		lens[9] = $urandom_range(0, 31);
		src_idle = 1'b1;
		sink_idle = 1'b1;
		long_hold = 1'b0;
		cycle_count = 0;
		bytes_sent = 0;
		settings_done = 0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tlast <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pattern: single zero char, never matches
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		settle();
		program_pattern(5'd4, pack_chars("*%@Q"), pack_chars("zzzzzzzz"));
		send_str("a0bQZ9zQ");
		send_str("/:[@`{Q");
		settle();
		// zero length acts as one
		program_pattern(5'd0, pack_chars("*"), '0);
		send_str("ab");
		settle();
		write_cfg(CFG_UNUSED, '1);
		cfg_valid <= 1'b0;
		send_str("c");
		settle();
		program_pattern(5'd2, pack_chars("Az"), '0);
		send_str("AzAz");

		for (int ph = 0; ph < 10; ph++) begin
			settle();
			src_idle = ($urandom_range(0, 3) != 0);
			sink_idle = ($urandom_range(0, 3) != 0);
			set_random_pattern(5'(lens[ph]));
			if (ph == 1) begin
				src_idle = 1'b0;
				long_hold = 1'b1;
			end
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_ITEMS) send_random_text();
		end

		// closing texts at full rate, no idling on either side
		settle();
		src_idle = 1'b0;
		sink_idle = 1'b0;
		program_pattern(5'd1, pack_chars("*"), '0);
		for (int i = 0; i < TAIL_LEN; i++)
			send_byte(8'($urandom_range(0, 255)), i == TAIL_LEN - 1);
		send_str("xy");
		settle();
		repeat (8) @(posedge clk);

		$display("Covered %0d bytes in %0d texts under %0d pattern settings,",
			bytes_sent, sb.texts_done, settings_done);
		$display("lengths 0 to 31, all char classes, a long output stall; %0d results checked",
			sb.results_seen);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
